@@ hdl/nar_pkg.sv @@
`default_nettype none

package nar_pkg;

    // Widths fixed by the item fields and the per-letter count.
    localparam int SYM_W = 5;
    localparam int CNT_W = 7;

    // Controls shared by every cell of the count ring.
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_FAIL,
        ST_EMIT
    } nar_state_t;

endpackage

`default_nettype wire

@@ hdl/nar_ram.sv @@
`default_nettype none

module nar_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

@@ hdl/nar_cell.sv @@
`default_nettype none

module nar_cell import nar_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cell_ctrl_t       ctrl,
    input  wire logic             inc,
    input  wire logic [CNT_W-1:0] shift_in,
    output logic      [CNT_W-1:0] count
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Clear wins over the ring shift, which wins over a load increment.
    always_comb
    begin
        if (ctrl.clear)
        begin
            count_next = '0;
        end
        else if (ctrl.shift)
        begin
            count_next = shift_in;
        end
        else if (inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign count = count_reg;

endmodule

`default_nettype wire

@@ hdl/nar_pick.sv @@
`default_nettype none

module nar_pick import nar_pkg::*; #(
    parameter int IDX_W = 5
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             en,
    input  wire logic             first,
    input  wire logic [IDX_W-1:0] code,
    input  wire logic [CNT_W-1:0] value,
    output logic      [IDX_W-1:0] top_code,
    output logic      [CNT_W-1:0] top_cnt,
    output logic      [IDX_W-1:0] sec_code,
    output logic      [CNT_W-1:0] sec_cnt
);

    logic [IDX_W-1:0] top_code_reg;
    logic [CNT_W-1:0] top_cnt_reg;
    logic [IDX_W-1:0] sec_code_reg;
    logic [CNT_W-1:0] sec_cnt_reg;
    logic [IDX_W-1:0] base1_code;
    logic [CNT_W-1:0] base1_cnt;
    logic [IDX_W-1:0] base2_code;
    logic [CNT_W-1:0] base2_cnt;
    logic             gt1;
    logic             gt2;

    // Ranking key is (count, code); a zero count never ranks.
    always_comb
    begin
        base1_code = first ? '0 : top_code_reg;
        base1_cnt  = first ? '0 : top_cnt_reg;
        base2_code = first ? '0 : sec_code_reg;
        base2_cnt  = first ? '0 : sec_cnt_reg;
        gt1 = (value != '0) &&
              ((value > base1_cnt) || ((value == base1_cnt) && (code > base1_code)));
        gt2 = (value != '0) &&
              ((value > base2_cnt) || ((value == base2_cnt) && (code > base2_code)));
        top_code = base1_code;
        top_cnt  = base1_cnt;
        sec_code = base2_code;
        sec_cnt  = base2_cnt;
        if (gt1)
        begin
            top_code = code;
            top_cnt  = value;
            sec_code = base1_code;
            sec_cnt  = base1_cnt;
        end
        else if (gt2)
        begin
            sec_code = code;
            sec_cnt  = value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_code_reg <= '0;
            top_cnt_reg  <= '0;
            sec_code_reg <= '0;
            sec_cnt_reg  <= '0;
        end
        else if (en)
        begin
            top_code_reg <= top_code;
            top_cnt_reg  <= top_cnt;
            sec_code_reg <= sec_code;
            sec_cnt_reg  <= sec_cnt;
        end
    end

endmodule

`default_nettype wire

@@ hdl/no_adjacent_repeat_rearranger_top.sv @@
// Rearranges a string of letters so that no two neighbors are equal.
// Input channel (in_valid/in_ready): one letter item per accepted cycle, with
// end_of_string on the final letter. Letters at or above ALPHABET are not
// counted, and letters past MAX_LEN are dropped; end_of_string still ends the
// string. in_ready is low from the end of a string until its last result
// has been taken.
// Output channel (out_valid/out_ready): one item per letter of the rearranged
// string, last_result on the final one, or a single item with failed set when
// no arrangement exists. An empty string gives no result at all.
// Search: letter counts sit in a ring of ALPHABET cells that rotates past a
// top-two picker; each greedy round passes every cell once, and a pair round
// yields two letters. Results are buffered in a MAX_LEN-deep RAM and then
// leave one item at a time; a new RAM read is not issued until the previous
// registered read has landed.
// A stalled receiver simply holds the output register; nothing is lost.
// Reset clears all counts and control state; counts also all clear together
// at the end of every search, so no clearing pass is needed.
`default_nettype none

module no_adjacent_repeat_rearranger_top import nar_pkg::*; #(
    parameter int ALPHABET = 26,
    parameter int MAX_LEN  = 64
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [SYM_W-1:0] symbol,
    input  wire logic             end_of_string,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic      [SYM_W-1:0] out_symbol,
    output logic                  failed,
    output logic                  last_result
);

    localparam int IDX_W  = $clog2(ALPHABET);
    localparam int LEN_W  = $clog2(MAX_LEN + 1);
    localparam int ADDR_W = $clog2(MAX_LEN);

    nar_state_t state_reg;
    nar_state_t state_next;

    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] n_reg;
    logic [LEN_W-1:0] n_next;
    logic [LEN_W-1:0] rd_ptr_reg;
    logic [LEN_W-1:0] rd_ptr_next;
    logic             rd_pend_reg;
    logic             rd_pend_next;
    logic             pend_b_reg;
    logic             pend_b_next;
    logic [IDX_W-1:0] pend_b_code_reg;
    logic [IDX_W-1:0] pend_b_code_next;
    logic             dec_en_reg;
    logic             dec_en_next;
    logic [IDX_W-1:0] dec_a_reg;
    logic [IDX_W-1:0] dec_a_next;
    logic [IDX_W-1:0] dec_b_reg;
    logic [IDX_W-1:0] dec_b_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [SYM_W-1:0] out_symbol_reg;
    logic [SYM_W-1:0] out_symbol_next;
    logic             out_failed_reg;
    logic             out_failed_next;
    logic             out_last_reg;
    logic             out_last_next;

    logic [CNT_W-1:0] cell_cnt [ALPHABET];
    logic             cell_inc [ALPHABET];
    cell_ctrl_t       ctrl;

    logic [CNT_W-1:0] head_val;
    logic             dec_hit;
    logic [IDX_W-1:0] top_code;
    logic [CNT_W-1:0] top_cnt;
    logic [IDX_W-1:0] sec_code;
    logic [CNT_W-1:0] sec_cnt;

    logic             in_acc;
    logic             count_ok;
    logic             scan;
    logic             round_end;
    logic             run_pair;
    logic             run_single;
    logic             run_fail;
    logic             run_empty;
    logic             run_end;
    logic             out_take;
    logic             issue;
    logic             ram_we;
    logic [SYM_W-1:0] ram_wdata;
    logic [SYM_W-1:0] ram_rdata;

    // Count ring. The head cell holds the letter whose code is idx_reg; while
    // scanning, its count goes round to the tail, less one if that letter was
    // picked in the previous round.
    assign dec_hit  = dec_en_reg && ((idx_reg == dec_a_reg) || (idx_reg == dec_b_reg));
    assign head_val = cell_cnt[0] - CNT_W'(dec_hit);

    for (genvar i = 0; i < ALPHABET; i++)
    begin : g_cell
        logic [CNT_W-1:0] shift_in;

        if (i == ALPHABET - 1)
        begin : g_tail
            assign shift_in = head_val;
        end
        else
        begin : g_body
            assign shift_in = cell_cnt[i + 1];
        end

        assign cell_inc[i] = in_acc && count_ok && (32'(symbol) == i);

        nar_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .ctrl     (ctrl),
            .inc      (cell_inc[i]),
            .shift_in (shift_in),
            .count    (cell_cnt[i])
        );
    end

    // Top-two picker watching the head of the ring. Its outputs include the
    // letter passing the head this cycle, so at the end of a round they hold
    // the winners of the whole alphabet.
    nar_pick #(
        .IDX_W (IDX_W)
    ) u_pick (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (scan),
        .first    (idx_reg == '0),
        .code     (idx_reg),
        .value    (head_val),
        .top_code (top_code),
        .top_cnt  (top_cnt),
        .sec_code (sec_code),
        .sec_cnt  (sec_cnt)
    );

    // Result buffer. A pair round writes its first letter at the round end and
    // its second from pend_b_reg in the cycle after; the next round end is never
    // that close, so the single write port never sees two writes at once.
    nar_ram #(
        .WIDTH (SYM_W),
        .DEPTH (MAX_LEN)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (n_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Control decode.
    always_comb
    begin
        in_ready   = (state_reg == ST_LOAD);
        in_acc     = in_valid && in_ready;
        count_ok   = (32'(symbol) < ALPHABET) && (len_reg < LEN_W'(MAX_LEN));
        scan       = (state_reg == ST_SCAN);
        round_end  = scan && (idx_reg == IDX_W'(ALPHABET - 1));
        run_pair   = round_end && (top_cnt != '0) && (sec_cnt != '0);
        run_single = round_end && (top_cnt == CNT_W'(1)) && (sec_cnt == '0);
        run_fail   = round_end && (top_cnt > CNT_W'(1)) && (sec_cnt == '0);
        run_empty  = round_end && (top_cnt == '0);
        run_end    = round_end && !run_pair;
        ctrl.shift = scan;
        ctrl.clear = run_end;
        out_take   = out_valid_reg && out_ready;
        issue      = (state_reg == ST_EMIT) && !rd_pend_reg && (rd_ptr_reg < n_reg) &&
                     (!out_valid_reg || out_ready);
        ram_we     = run_pair || run_single || pend_b_reg;
        ram_wdata  = pend_b_reg ? SYM_W'(pend_b_code_reg) : SYM_W'(top_code);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_acc && end_of_string)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (run_fail)
                begin
                    state_next = ST_FAIL;
                end
                else if (run_empty && (n_reg == '0))
                begin
                    state_next = ST_LOAD;
                end
                else if (run_end)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_FAIL:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_take && out_last_reg)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Datapath and output register next values.
    always_comb
    begin
        len_next         = len_reg;
        idx_next         = idx_reg;
        n_next           = n_reg;
        rd_ptr_next      = rd_ptr_reg;
        rd_pend_next     = issue;
        pend_b_next      = run_pair;
        pend_b_code_next = pend_b_code_reg;
        dec_en_next      = dec_en_reg;
        dec_a_next       = dec_a_reg;
        dec_b_next       = dec_b_reg;
        out_valid_next   = out_valid_reg;
        out_symbol_next  = out_symbol_reg;
        out_failed_next  = out_failed_reg;
        out_last_next    = out_last_reg;

        if (in_acc && count_ok)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        if (run_end)
        begin
            len_next    = '0;
            dec_en_next = 1'b0;
        end

        if (scan)
        begin
            idx_next = round_end ? '0 : idx_reg + IDX_W'(1);
        end

        if (run_pair)
        begin
            pend_b_code_next = sec_code;
            dec_en_next      = 1'b1;
            dec_a_next       = top_code;
            dec_b_next       = sec_code;
        end

        if (ram_we)
        begin
            n_next = n_reg + LEN_W'(1);
        end

        if (issue)
        begin
            rd_ptr_next = rd_ptr_reg + LEN_W'(1);
        end

        if (out_take)
        begin
            out_valid_next = 1'b0;
        end

        // The output register is always empty when read data lands, because
        // a read is only issued when it is empty or being emptied.
        if (rd_pend_reg)
        begin
            out_valid_next  = 1'b1;
            out_symbol_next = ram_rdata;
            out_failed_next = 1'b0;
            out_last_next   = (rd_ptr_reg == n_reg);
        end

        // A failure discards any letters already buffered.
        if (state_reg == ST_FAIL)
        begin
            out_valid_next  = 1'b1;
            out_symbol_next = '0;
            out_failed_next = 1'b1;
            out_last_next   = 1'b1;
            n_next          = '0;
            rd_ptr_next     = '0;
        end

        if ((state_reg == ST_EMIT) && out_take && out_last_reg)
        begin
            n_next      = '0;
            rd_ptr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            idx_reg       <= '0;
            len_reg       <= '0;
            n_reg         <= '0;
            rd_ptr_reg    <= '0;
            rd_pend_reg   <= 1'b0;
            pend_b_reg    <= 1'b0;
            dec_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            len_reg       <= len_next;
            n_reg         <= n_next;
            rd_ptr_reg    <= rd_ptr_next;
            rd_pend_reg   <= rd_pend_next;
            pend_b_reg    <= pend_b_next;
            dec_en_reg    <= dec_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_b_code_reg <= pend_b_code_next;
        dec_a_reg       <= dec_a_next;
        dec_b_reg       <= dec_b_next;
        out_symbol_reg  <= out_symbol_next;
        out_failed_reg  <= out_failed_next;
        out_last_reg    <= out_last_next;
    end

    assign out_valid   = out_valid_reg;
    assign out_symbol  = out_symbol_reg;
    assign failed      = out_failed_reg;
    assign last_result = out_last_reg;

`ifndef SYNTH
    // Loading only starts once every result of the previous string is gone.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input accepted while a result is pending");

    // The final letter of a string closes the input until the run is done.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && end_of_string) |=> !in_ready)
        else $error("input still open after end of string");

    // A buffer read must land in an empty output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> !out_valid_reg)
        else $error("buffer read overwrites a pending result");

    // A failure is always the only and final result of its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && failed) |-> (last_result && (out_symbol == '0)))
        else $error("malformed failure result");
`endif

endmodule

`default_nettype wire
